@@ hw/rtl/fnst_pkg.sv @@
`default_nettype none
package fnst_pkg;

    localparam int COORD_BITS = 32;
    localparam int ANGLE_BITS = 16;
    localparam int LANES      = 4;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int NORM_TOP   = 59;
    localparam int NORM_W     = NORM_TOP + 1;
    localparam int CW         = NORM_W + 3;
    localparam int SHIFT_W    = 6;
    localparam int Z_W        = 32;
    localparam int Q_W        = 31;
    localparam int STEPS      = 31;
    localparam int GAP_W      = ANGLE_BITS + 1;

    localparam logic signed [Z_W-1:0] EIGHTH_TURN  = 32'sd536870912;
    localparam logic [Q_W-1:0]        QUARTER_TURN = 31'h4000_0000;

    typedef enum logic [1:0] {
        OCT_CORDIC,
        OCT_AXIS,
        OCT_DIAG,
        OCT_NULL
    } oct_code_t;

    typedef struct packed {
        oct_code_t code;
        logic      swap;
        logic      xneg;
        logic      yneg;
    } lane_meta_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] origin_x;
        logic signed [COORD_BITS-1:0] origin_y;
        logic signed [COORD_BITS-1:0] a_x;
        logic signed [COORD_BITS-1:0] a_y;
        logic signed [COORD_BITS-1:0] b_x;
        logic signed [COORD_BITS-1:0] b_y;
        logic signed [COORD_BITS-1:0] c_x;
        logic signed [COORD_BITS-1:0] c_y;
        logic signed [COORD_BITS-1:0] d_x;
        logic signed [COORD_BITS-1:0] d_y;
    } in_word_t;

    typedef struct packed {
        logic             surrounded;
        logic [GAP_W-1:0] largest_gap;
    } out_word_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic signed [Z_W-1:0] turn_step(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0: v = 32'sd536870912;
            1: v = 32'sd316933406;
            2: v = 32'sd167458907;
            3: v = 32'sd85004756;
            4: v = 32'sd42667331;
            5: v = 32'sd21354465;
            6: v = 32'sd10680862;
            7: v = 32'sd5340245;
            8: v = 32'sd2670163;
            9: v = 32'sd1335087;
            10: v = 32'sd667544;
            11: v = 32'sd333772;
            12: v = 32'sd166886;
            13: v = 32'sd83443;
            14: v = 32'sd41722;
            15: v = 32'sd20861;
            16: v = 32'sd10430;
            17: v = 32'sd5215;
            18: v = 32'sd2608;
            19: v = 32'sd1304;
            20: v = 32'sd652;
            21: v = 32'sd326;
            22: v = 32'sd163;
            23: v = 32'sd81;
            24: v = 32'sd41;
            25: v = 32'sd20;
            26: v = 32'sd10;
            27: v = 32'sd5;
            28: v = 32'sd3;
            29: v = 32'sd1;
            30: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/four_neighbour_surround_test.sv @@
// an accepted word passes prep, cordic, unfold, gap and the output register to m_word
// one word per cycle unless stalled; the 31-stage cordic pipeline per neighbour sets the depth
// the whole pipeline advances when the output register is empty or being taken
// reset (aresetn low, synchronous) clears the valid bits only; datapath registers are not reset
`default_nettype none
module four_neighbour_surround_test (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire fnst_pkg::in_word_t   s_word,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output fnst_pkg::out_word_t       m_word
);
    localparam int Lanes = fnst_pkg::LANES;
    localparam int Gw    = fnst_pkg::GAP_W;

    logic en;
    logic prep_valid, cordic_valid, unfold_valid, gap_valid;
    logic signed [fnst_pkg::CW-1:0] prep_x [Lanes];
    logic signed [fnst_pkg::CW-1:0] prep_y [Lanes];
    fnst_pkg::lane_meta_t prep_meta [Lanes];
    logic signed [fnst_pkg::Z_W-1:0] cordic_z [Lanes];
    fnst_pkg::lane_meta_t cordic_meta [Lanes];
    logic [fnst_pkg::ANGLE_BITS-1:0] angle [Lanes];
    logic [Gw-1:0] gap [Lanes];

    logic out_valid_reg, out_valid_next;
    fnst_pkg::out_word_t out_word_reg, out_word_next;

    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    fnst_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_word   (s_word),
        .out_valid (prep_valid),
        .out_x     (prep_x),
        .out_y     (prep_y),
        .out_meta  (prep_meta)
    );

    fnst_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (prep_valid),
        .in_x      (prep_x),
        .in_y      (prep_y),
        .in_meta   (prep_meta),
        .out_valid (cordic_valid),
        .out_z     (cordic_z),
        .out_meta  (cordic_meta)
    );

    fnst_unfold u_unfold (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (cordic_valid),
        .in_z      (cordic_z),
        .in_meta   (cordic_meta),
        .out_valid (unfold_valid),
        .out_angle (angle)
    );

    fnst_gap u_gap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (unfold_valid),
        .in_angle  (angle),
        .out_valid (gap_valid),
        .out_gap   (gap)
    );

    always_comb begin
        logic [Gw-1:0] m01;
        logic [Gw-1:0] m23;
        logic [Gw-1:0] best;
        m01 = (gap[1] > gap[0]) ? gap[1] : gap[0];
        m23 = (gap[3] > gap[2]) ? gap[3] : gap[2];
        best = (m23 > m01) ? m23 : m01;
        out_word_next.largest_gap = best;
        out_word_next.surrounded  = best < (Gw'(1) << (fnst_pkg::ANGLE_BITS - 1));
        out_valid_next = en ? gap_valid : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_word_reg <= out_word_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_word  = out_word_reg;

endmodule
`default_nettype wire

@@ hw/rtl/fnst_prep.sv @@
`default_nettype none
module fnst_prep (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                en,
    input  wire logic                                in_valid,
    input  wire fnst_pkg::in_word_t                  in_word,
    output logic                                     out_valid,
    output logic signed [fnst_pkg::CW-1:0]           out_x [fnst_pkg::LANES],
    output logic signed [fnst_pkg::CW-1:0]           out_y [fnst_pkg::LANES],
    output fnst_pkg::lane_meta_t                     out_meta [fnst_pkg::LANES]
);
    localparam int DiffW = fnst_pkg::DIFF_W;
    localparam int NormW = fnst_pkg::NORM_W;
    localparam int Cw    = fnst_pkg::CW;
    localparam int ShW   = fnst_pkg::SHIFT_W;
    localparam int Lanes = fnst_pkg::LANES;

    logic signed [fnst_pkg::COORD_BITS-1:0] px [Lanes];
    logic signed [fnst_pkg::COORD_BITS-1:0] py [Lanes];

    logic signed [DiffW-1:0] dx_reg [Lanes], dx_next [Lanes];
    logic signed [DiffW-1:0] dy_reg [Lanes], dy_next [Lanes];
    logic [DiffW-1:0] big_reg [Lanes], big_next [Lanes];
    logic [DiffW-1:0] small_reg [Lanes], small_next [Lanes];
    fnst_pkg::lane_meta_t meta2_reg [Lanes], meta2_next [Lanes];
    logic [DiffW-1:0] big3_reg [Lanes];
    logic [DiffW-1:0] small3_reg [Lanes];
    logic [ShW-1:0] sh_reg [Lanes], sh_next [Lanes];
    fnst_pkg::lane_meta_t meta3_reg [Lanes];
    logic signed [Cw-1:0] x_reg [Lanes], x_next [Lanes];
    logic signed [Cw-1:0] y_reg [Lanes], y_next [Lanes];
    fnst_pkg::lane_meta_t meta4_reg [Lanes];
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    assign px[0] = in_word.a_x;
    assign py[0] = in_word.a_y;
    assign px[1] = in_word.b_x;
    assign py[1] = in_word.b_y;
    assign px[2] = in_word.c_x;
    assign py[2] = in_word.c_y;
    assign px[3] = in_word.d_x;
    assign py[3] = in_word.d_y;

    always_comb begin
        for (int l = 0; l < Lanes; l++) begin
            dx_next[l] = DiffW'(px[l]) - DiffW'(in_word.origin_x);
            dy_next[l] = DiffW'(py[l]) - DiffW'(in_word.origin_y);
        end
    end

    // fold into the first octant
    always_comb begin
        logic [DiffW-1:0] ax;
        logic [DiffW-1:0] ay;
        for (int l = 0; l < Lanes; l++) begin
            ax = dx_reg[l][DiffW-1] ? DiffW'(-dx_reg[l]) : DiffW'(dx_reg[l]);
            ay = dy_reg[l][DiffW-1] ? DiffW'(-dy_reg[l]) : DiffW'(dy_reg[l]);
            meta2_next[l].swap = ay > ax;
            meta2_next[l].xneg = dx_reg[l][DiffW-1];
            meta2_next[l].yneg = dy_reg[l][DiffW-1];
            big_next[l]   = (ay > ax) ? ay : ax;
            small_next[l] = (ay > ax) ? ax : ay;
            if (ax == '0 && ay == '0) begin
                meta2_next[l].code = fnst_pkg::OCT_NULL;
            end else if (small_next[l] == '0) begin
                meta2_next[l].code = fnst_pkg::OCT_AXIS;
            end else if (small_next[l] == big_next[l]) begin
                meta2_next[l].code = fnst_pkg::OCT_DIAG;
            end else begin
                meta2_next[l].code = fnst_pkg::OCT_CORDIC;
            end
        end
    end

    // leading one of the larger magnitude
    always_comb begin
        logic [ShW-1:0] top;
        for (int l = 0; l < Lanes; l++) begin
            top = '0;
            for (int b = 0; b < DiffW; b++) begin
                if (big_reg[l][b]) begin
                    top = ShW'(b);
                end
            end
            sh_next[l] = ShW'(fnst_pkg::NORM_TOP) - top;
        end
    end

    always_comb begin
        for (int l = 0; l < Lanes; l++) begin
            x_next[l] = signed'(Cw'(NormW'(big3_reg[l]) << sh_reg[l]));
            y_next[l] = signed'(Cw'(NormW'(small3_reg[l]) << sh_reg[l]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            big_reg    <= big_next;
            small_reg  <= small_next;
            meta2_reg  <= meta2_next;
            big3_reg   <= big_reg;
            small3_reg <= small_reg;
            sh_reg     <= sh_next;
            meta3_reg  <= meta2_reg;
            x_reg      <= x_next;
            y_reg      <= y_next;
            meta4_reg  <= meta3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_meta  = meta4_reg;

endmodule
`default_nettype wire

@@ hw/rtl/fnst_cordic.sv @@
`default_nettype none
module fnst_cordic (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                en,
    input  wire logic                                in_valid,
    input  wire logic signed [fnst_pkg::CW-1:0]      in_x [fnst_pkg::LANES],
    input  wire logic signed [fnst_pkg::CW-1:0]      in_y [fnst_pkg::LANES],
    input  wire fnst_pkg::lane_meta_t                in_meta [fnst_pkg::LANES],
    output logic                                     out_valid,
    output logic signed [fnst_pkg::Z_W-1:0]          out_z [fnst_pkg::LANES],
    output fnst_pkg::lane_meta_t                     out_meta [fnst_pkg::LANES]
);
    localparam int Cw    = fnst_pkg::CW;
    localparam int Zw    = fnst_pkg::Z_W;
    localparam int Lanes = fnst_pkg::LANES;
    localparam int Steps = fnst_pkg::STEPS;

    logic signed [Cw-1:0] x_reg [Steps][Lanes];
    logic signed [Cw-1:0] y_reg [Steps][Lanes];
    logic signed [Zw-1:0] z_reg [Steps][Lanes];
    fnst_pkg::lane_meta_t meta_reg [Steps][Lanes];
    logic [Steps-1:0] v_reg;

    for (genvar s = 0; s < Steps; s++) begin : g_step
        logic signed [Cw-1:0] x_in [Lanes];
        logic signed [Cw-1:0] y_in [Lanes];
        logic signed [Zw-1:0] z_in [Lanes];
        fnst_pkg::lane_meta_t meta_in [Lanes];
        logic v_in;
        logic signed [Cw-1:0] x_next [Lanes];
        logic signed [Cw-1:0] y_next [Lanes];
        logic signed [Zw-1:0] z_next [Lanes];

        if (s == 0) begin : g_first
            assign x_in    = in_x;
            assign y_in    = in_y;
            assign meta_in = in_meta;
            assign v_in    = in_valid;
            always_comb begin
                for (int l = 0; l < Lanes; l++) begin
                    z_in[l] = '0;
                end
            end
        end else begin : g_rest
            assign x_in    = x_reg[s-1];
            assign y_in    = y_reg[s-1];
            assign z_in    = z_reg[s-1];
            assign meta_in = meta_reg[s-1];
            assign v_in    = v_reg[s-1];
        end

        // rotate toward the x axis, direction from the sign of y
        always_comb begin
            for (int l = 0; l < Lanes; l++) begin
                if (!y_in[l][Cw-1]) begin
                    x_next[l] = x_in[l] + (y_in[l] >>> s);
                    y_next[l] = y_in[l] - (x_in[l] >>> s);
                    z_next[l] = z_in[l] + fnst_pkg::turn_step(s);
                end else begin
                    x_next[l] = x_in[l] - (y_in[l] >>> s);
                    y_next[l] = y_in[l] + (x_in[l] >>> s);
                    z_next[l] = z_in[l] - fnst_pkg::turn_step(s);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (en) begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[s]    <= x_next;
                y_reg[s]    <= y_next;
                z_reg[s]    <= z_next;
                meta_reg[s] <= meta_in;
            end
        end
    end

    assign out_valid = v_reg[Steps-1];
    assign out_z     = z_reg[Steps-1];
    assign out_meta  = meta_reg[Steps-1];

endmodule
`default_nettype wire

@@ hw/rtl/fnst_unfold.sv @@
`default_nettype none
module fnst_unfold (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                en,
    input  wire logic                                in_valid,
    input  wire logic signed [fnst_pkg::Z_W-1:0]     in_z [fnst_pkg::LANES],
    input  wire fnst_pkg::lane_meta_t                in_meta [fnst_pkg::LANES],
    output logic                                     out_valid,
    output logic [fnst_pkg::ANGLE_BITS-1:0]          out_angle [fnst_pkg::LANES]
);
    localparam int Qw    = fnst_pkg::Q_W;
    localparam int Tw    = fnst_pkg::Z_W + 1;
    localparam int Ab    = fnst_pkg::ANGLE_BITS;
    localparam int Lanes = fnst_pkg::LANES;
    localparam logic [Tw-1:0] HalfTurn = Tw'(1) << (Tw - 2);
    localparam logic [Tw-1:0] FullTurn = Tw'(1) << (Tw - 1);
    localparam logic [Tw-1:0] RoundBit = Tw'(1) << (Tw - 2 - Ab);

    logic [Qw-1:0] q_reg [Lanes], q_next [Lanes];
    fnst_pkg::lane_meta_t meta_reg [Lanes];
    logic [Ab-1:0] angle_reg [Lanes], angle_next [Lanes];
    logic v1_reg, v2_reg;

    always_comb begin
        logic [Qw-1:0] q0;
        for (int l = 0; l < Lanes; l++) begin
            case (in_meta[l].code)
                fnst_pkg::OCT_AXIS, fnst_pkg::OCT_NULL: q0 = '0;
                fnst_pkg::OCT_DIAG: q0 = Qw'(fnst_pkg::EIGHTH_TURN);
                default: begin
                    if (in_z[l][fnst_pkg::Z_W-1]) begin
                        q0 = '0;
                    end else if (in_z[l] > fnst_pkg::EIGHTH_TURN) begin
                        q0 = Qw'(fnst_pkg::EIGHTH_TURN);
                    end else begin
                        q0 = Qw'(in_z[l]);
                    end
                end
            endcase
            q_next[l] = in_meta[l].swap ? fnst_pkg::QUARTER_TURN - q0 : q0;
        end
    end

    // quadrant unfold, then round half up to the output angle width
    always_comb begin
        logic [Tw-1:0] t;
        logic [Tw-1:0] r;
        for (int l = 0; l < Lanes; l++) begin
            if (!meta_reg[l].yneg) begin
                t = meta_reg[l].xneg ? HalfTurn - Tw'(q_reg[l]) : Tw'(q_reg[l]);
            end else begin
                t = meta_reg[l].xneg ? HalfTurn + Tw'(q_reg[l]) : FullTurn - Tw'(q_reg[l]);
            end
            r = {1'b0, t[Tw-2:0]} + RoundBit;
            angle_next[l] = (meta_reg[l].code == fnst_pkg::OCT_NULL) ? '0 : r[Tw-2 -: Ab];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg     <= q_next;
            meta_reg  <= in_meta;
            angle_reg <= angle_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_angle = angle_reg;

endmodule
`default_nettype wire

@@ hw/rtl/fnst_gap.sv @@
`default_nettype none
module fnst_gap (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                en,
    input  wire logic                                in_valid,
    input  wire logic [fnst_pkg::ANGLE_BITS-1:0]     in_angle [fnst_pkg::LANES],
    output logic                                     out_valid,
    output logic [fnst_pkg::GAP_W-1:0]               out_gap [fnst_pkg::LANES]
);
    localparam int Ab    = fnst_pkg::ANGLE_BITS;
    localparam int Gw    = fnst_pkg::GAP_W;
    localparam int Lanes = fnst_pkg::LANES;

    logic [Ab-1:0] s1_reg [Lanes], s1_next [Lanes];
    logic [Ab-1:0] s2_reg [Lanes], s2_next [Lanes];
    logic [Ab-1:0] s3_reg [Lanes], s3_next [Lanes];
    logic [Gw-1:0] gap_reg [Lanes], gap_next [Lanes];
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // sorting network: (0,1)(2,3) then (0,2)(1,3) then (1,2)
    always_comb begin
        s1_next[0] = (in_angle[0] > in_angle[1]) ? in_angle[1] : in_angle[0];
        s1_next[1] = (in_angle[0] > in_angle[1]) ? in_angle[0] : in_angle[1];
        s1_next[2] = (in_angle[2] > in_angle[3]) ? in_angle[3] : in_angle[2];
        s1_next[3] = (in_angle[2] > in_angle[3]) ? in_angle[2] : in_angle[3];
    end

    always_comb begin
        s2_next[0] = (s1_reg[0] > s1_reg[2]) ? s1_reg[2] : s1_reg[0];
        s2_next[2] = (s1_reg[0] > s1_reg[2]) ? s1_reg[0] : s1_reg[2];
        s2_next[1] = (s1_reg[1] > s1_reg[3]) ? s1_reg[3] : s1_reg[1];
        s2_next[3] = (s1_reg[1] > s1_reg[3]) ? s1_reg[1] : s1_reg[3];
    end

    always_comb begin
        s3_next[0] = s2_reg[0];
        s3_next[3] = s2_reg[3];
        s3_next[1] = (s2_reg[1] > s2_reg[2]) ? s2_reg[2] : s2_reg[1];
        s3_next[2] = (s2_reg[1] > s2_reg[2]) ? s2_reg[1] : s2_reg[2];
    end

    // last gap wraps through a full turn
    always_comb begin
        for (int l = 0; l < Lanes - 1; l++) begin
            gap_next[l] = Gw'(s3_reg[l + 1]) - Gw'(s3_reg[l]);
        end
        gap_next[Lanes-1] = Gw'(s3_reg[0]) + (Gw'(1) << Ab) - Gw'(s3_reg[Lanes-1]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            gap_reg <= gap_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_gap   = gap_reg;

endmodule
`default_nettype wire
